@@ sv/sfs_pkg.sv @@
`timescale 1ns / 1ps
// Package for the sprite frame sequencer: widths, register map, play mode bits,
// sequencer states and the structs passed between the block's modules.
// No dependencies.
package sfs_pkg;

	localparam int FRAME_W = 10;
	localparam int CNT_W = 9;
	localparam int OFS_W = 20;
	localparam int DIM_W = 13;
	localparam int LIFE_W = 32;
	localparam int MODE_W = 2;
	localparam int APB_DW = 32;
	localparam int APB_AW = 5;
	localparam int PROD_W = CNT_W + DIM_W;

	localparam int FRAME_INTERVAL_RESET = 100000;
	localparam logic [CNT_W-1:0] FRAME_COUNT_RESET = CNT_W'(1);
	localparam logic [CNT_W-1:0] FRAMES_PER_ROW_RESET = CNT_W'(1);
	localparam logic [DIM_W-1:0] FRAME_DIM_RESET = DIM_W'(1);

	localparam int MODE_REPEAT_BIT = 0;
	localparam int MODE_PINGPONG_BIT = 1;

	// Serial divider operand widths.
	localparam int DIV_DW = FRAME_W;
	localparam int DIV_VW = CNT_W;
	localparam int DIV_CNT_W = $clog2(DIV_DW + 1);

	typedef enum logic [2:0] {
		REG_FRAME_INTERVAL,
		REG_START_DELAY,
		REG_LIFESPAN,
		REG_FRAME_COUNT,
		REG_FRAMES_PER_ROW,
		REG_PLAY_MODE,
		REG_FRAME_WIDTH,
		REG_FRAME_HEIGHT
	} sfs_reg_e;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EVAL,
		ST_CHECK,
		ST_MOD_GO,
		ST_MOD_WAIT,
		ST_LAND,
		ST_ROW_GO,
		ST_ROW_WAIT,
		ST_MUL_LEFT,
		ST_MUL_TOP,
		ST_FINISH
	} sfs_state_e;

	typedef struct packed {
		logic [LIFE_W-1:0] lifespan;
		logic [CNT_W-1:0]  frame_count;
		logic [CNT_W-1:0]  frames_per_row;
		logic [MODE_W-1:0] play_mode;
		logic [DIM_W-1:0]  frame_width;
		logic [DIM_W-1:0]  frame_height;
	} sfs_cfg_t;

	typedef struct packed {
		logic              start;
		logic [DIV_DW-1:0] dividend;
		logic [DIV_VW-1:0] divisor;
	} sfs_div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_DW-1:0] quot;
		logic [DIV_VW-1:0] rem;
	} sfs_div_rsp_t;

	typedef struct packed {
		logic signed [FRAME_W-1:0] frame_index;
		logic [OFS_W-1:0]          sheet_left;
		logic [OFS_W-1:0]          sheet_top;
		logic                      visible;
		logic                      expired;
		logic                      frame_advanced;
	} sfs_result_t;

endpackage

@@ sv/sfs_ifs.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the sprite frame sequencer: the tick input
// and the result output. Depends on sfs_pkg.
interface sfs_tick_if #(
	parameter int TIME_BITS = 24
);
	logic                 valid;
	logic                 ready;
	logic [TIME_BITS-1:0] tick_time;

	modport source(output valid, output tick_time, input ready);
	modport sink(input valid, input tick_time, output ready);
endinterface

interface sfs_res_if;
	logic                                valid;
	logic                                ready;
	logic signed [sfs_pkg::FRAME_W-1:0] frame_index;
	logic [sfs_pkg::OFS_W-1:0]          sheet_left;
	logic [sfs_pkg::OFS_W-1:0]          sheet_top;
	logic                                visible;
	logic                                expired;
	logic                                frame_advanced;

	modport source(output valid, output frame_index, output sheet_left, output sheet_top,
		output visible, output expired, output frame_advanced, input ready);
	modport sink(input valid, input frame_index, input sheet_left, input sheet_top,
		input visible, input expired, input frame_advanced, output ready);
endinterface

@@ sv/sfs_regs.sv @@
`timescale 1ns / 1ps
// APB-style configuration registers of the sprite frame sequencer.
// Depends on sfs_pkg.
module sfs_regs #(
	parameter int TIME_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sfs_pkg::APB_AW-1:0]  paddr,
	input  logic [sfs_pkg::APB_DW-1:0]  pwdata,
	output logic [sfs_pkg::APB_DW-1:0]  prdata,
	output logic                         pready,
	output logic [TIME_BITS-1:0]         frame_interval,
	output sfs_pkg::sfs_cfg_t            cfg,
	output logic                         delay_load,
	output logic [TIME_BITS-1:0]         delay_value
);

	logic [TIME_BITS-1:0] interval_q;
	logic [TIME_BITS-1:0] start_delay_q;
	sfs_pkg::sfs_cfg_t    cfg_q;
	sfs_pkg::sfs_reg_e    idx;
	logic                 wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign idx = sfs_pkg::sfs_reg_e'(paddr[sfs_pkg::APB_AW-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= TIME_BITS'(sfs_pkg::FRAME_INTERVAL_RESET);
			start_delay_q <= '0;
			cfg_q.lifespan <= '0;
			cfg_q.frame_count <= sfs_pkg::FRAME_COUNT_RESET;
			cfg_q.frames_per_row <= sfs_pkg::FRAMES_PER_ROW_RESET;
			cfg_q.play_mode <= '0;
			cfg_q.frame_width <= sfs_pkg::FRAME_DIM_RESET;
			cfg_q.frame_height <= sfs_pkg::FRAME_DIM_RESET;
		end else if (wr_en) begin
			unique case (idx)
				sfs_pkg::REG_FRAME_INTERVAL: interval_q <= pwdata[TIME_BITS-1:0];
				sfs_pkg::REG_START_DELAY:    start_delay_q <= pwdata[TIME_BITS-1:0];
				sfs_pkg::REG_LIFESPAN:       cfg_q.lifespan <= pwdata[sfs_pkg::LIFE_W-1:0];
				sfs_pkg::REG_FRAME_COUNT:    cfg_q.frame_count <= pwdata[sfs_pkg::CNT_W-1:0];
				sfs_pkg::REG_FRAMES_PER_ROW: cfg_q.frames_per_row <= pwdata[sfs_pkg::CNT_W-1:0];
				sfs_pkg::REG_PLAY_MODE:      cfg_q.play_mode <= pwdata[sfs_pkg::MODE_W-1:0];
				sfs_pkg::REG_FRAME_WIDTH:    cfg_q.frame_width <= pwdata[sfs_pkg::DIM_W-1:0];
				sfs_pkg::REG_FRAME_HEIGHT:   cfg_q.frame_height <= pwdata[sfs_pkg::DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			sfs_pkg::REG_FRAME_INTERVAL: prdata = sfs_pkg::APB_DW'(interval_q);
			sfs_pkg::REG_START_DELAY:    prdata = sfs_pkg::APB_DW'(start_delay_q);
			sfs_pkg::REG_LIFESPAN:       prdata = sfs_pkg::APB_DW'(cfg_q.lifespan);
			sfs_pkg::REG_FRAME_COUNT:    prdata = sfs_pkg::APB_DW'(cfg_q.frame_count);
			sfs_pkg::REG_FRAMES_PER_ROW: prdata = sfs_pkg::APB_DW'(cfg_q.frames_per_row);
			sfs_pkg::REG_PLAY_MODE:      prdata = sfs_pkg::APB_DW'(cfg_q.play_mode);
			sfs_pkg::REG_FRAME_WIDTH:    prdata = sfs_pkg::APB_DW'(cfg_q.frame_width);
			sfs_pkg::REG_FRAME_HEIGHT:   prdata = sfs_pkg::APB_DW'(cfg_q.frame_height);
			default:                     prdata = '0;
		endcase
	end

	// A start delay write also restarts the delay countdown.
	assign delay_load = wr_en && (idx == sfs_pkg::REG_START_DELAY);
	assign delay_value = pwdata[TIME_BITS-1:0];
	assign frame_interval = interval_q;
	assign cfg = cfg_q;

endmodule

@@ sv/sfs_div.sv @@
`timescale 1ns / 1ps
// Shared serial restoring divider: one quotient bit per cycle.
// Depends on sfs_pkg.
module sfs_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sfs_pkg::sfs_div_req_t req,
	output sfs_pkg::sfs_div_rsp_t rsp
);

	logic [sfs_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          done_q;
	logic [sfs_pkg::DIV_DW-1:0]    quo_q;
	logic [sfs_pkg::DIV_VW-1:0]    rem_q;
	logic [sfs_pkg::DIV_VW-1:0]    dvs_q;
	logic [sfs_pkg::DIV_VW:0]      trial;
	logic                          fits;
	logic [sfs_pkg::DIV_VW:0]      diff;

	// The partial remainder stays below the divisor, so the trial fits one extra bit.
	assign trial = {rem_q, quo_q[sfs_pkg::DIV_DW-1]};
	assign fits = trial >= {1'b0, dvs_q};
	assign diff = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == sfs_pkg::DIV_CNT_W'(1));
			if (req.start) begin
				cnt_q <= sfs_pkg::DIV_CNT_W'(sfs_pkg::DIV_DW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - sfs_pkg::DIV_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[sfs_pkg::DIV_DW-2:0], fits};
			rem_q <= fits ? diff[sfs_pkg::DIV_VW-1:0] : trial[sfs_pkg::DIV_VW-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem = rem_q;

endmodule

@@ sv/sfs_seq.sv @@
`timescale 1ns / 1ps
// Sequencer of the sprite frame sequencer: animation state, tick evaluation,
// frame stepping and sheet offsets, using the shared divider. Depends on sfs_pkg.
module sfs_seq #(
	parameter int TIME_BITS = 24,
	parameter int MAX_FRAMES = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [TIME_BITS-1:0]   frame_interval,
	input  sfs_pkg::sfs_cfg_t      cfg,
	input  logic                   delay_load,
	input  logic [TIME_BITS-1:0]   delay_value,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [TIME_BITS-1:0]   tick_time,
	output logic                   out_valid,
	input  logic                   out_ready,
	output sfs_pkg::sfs_result_t   out_data,
	output sfs_pkg::sfs_div_req_t  div_req,
	input  sfs_pkg::sfs_div_rsp_t  div_rsp
);

	localparam int ACC_W = TIME_BITS + 1;
	localparam int LIM_W = ($clog2(MAX_FRAMES + 1) > sfs_pkg::CNT_W) ?
		$clog2(MAX_FRAMES + 1) : sfs_pkg::CNT_W;
	localparam int FW = sfs_pkg::FRAME_W;
	localparam int CW = sfs_pkg::CNT_W;

	sfs_pkg::sfs_state_e state_q, state_d;

	logic signed [FW-1:0]    cur_q;
	logic                    back_q;
	logic [ACC_W-1:0]        acc_q;
	logic [sfs_pkg::LIFE_W-1:0] alive_q;
	logic [TIME_BITS-1:0]    dly_q;
	logic [sfs_pkg::OFS_W-1:0] left_q, top_q;
	logic                    out_valid_q;
	sfs_pkg::sfs_result_t    out_q;

	logic [TIME_BITS-1:0]    tick_q;
	logic                    wexp_q;
	logic                    adv_q;
	logic signed [FW:0]      sum_q;
	logic [FW-1:0]           nxt_q;
	logic [CW-1:0]           col_q, row_q;

	logic [CW-1:0]           n_eff, fpr_eff;
	logic                    rep, pp;
	logic signed [FW:0]      n_s, cur_x, nxt_x, step_sum, sum_neg;
	logic                    life_over, seq_done, exp_now;
	logic [ACC_W:0]          acc_sum;
	logic [ACC_W-1:0]        acc_sat;
	logic [sfs_pkg::LIFE_W:0] alive_sum;
	logic [sfs_pkg::LIFE_W-1:0] alive_sat;
	logic                    step_ok;
	logic [FW-1:0]           sum_abs, mod_frame;
	logic                    land_flip, land_in_range;
	logic [sfs_pkg::PROD_W-1:0] mul_a, mul_b, prod;
	logic                    out_load;
	sfs_pkg::sfs_result_t    result_d;

	// Effective counts: zero is taken as one, the frame count is capped.
	always_comb begin
		if (cfg.frame_count == '0) begin
			n_eff = CW'(1);
		end else if (LIM_W'(cfg.frame_count) > LIM_W'(MAX_FRAMES)) begin
			n_eff = CW'(MAX_FRAMES);
		end else begin
			n_eff = cfg.frame_count;
		end
		fpr_eff = (cfg.frames_per_row == '0) ? CW'(1) : cfg.frames_per_row;
	end

	assign rep = cfg.play_mode[sfs_pkg::MODE_REPEAT_BIT];
	assign pp = cfg.play_mode[sfs_pkg::MODE_PINGPONG_BIT];
	assign n_s = {2'b00, n_eff};
	assign cur_x = {cur_q[FW-1], cur_q};
	assign nxt_x = {nxt_q[FW-1], nxt_q};

	// Expiry of the present state: lifespan overrun or a finished one-shot run.
	assign life_over = (cfg.lifespan != '0) && (alive_q > cfg.lifespan);
	assign seq_done = !rep && (pp ? cur_q[FW-1] : (cur_x >= n_s));
	assign exp_now = life_over || seq_done;

	assign acc_sum = {1'b0, acc_q} + (ACC_W + 1)'(tick_q);
	assign acc_sat = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
	assign alive_sum = {1'b0, alive_q} + (sfs_pkg::LIFE_W + 1)'(tick_q);
	assign alive_sat = alive_sum[sfs_pkg::LIFE_W] ? '1 : alive_sum[sfs_pkg::LIFE_W-1:0];

	assign step_ok = !wexp_q && (acc_q >= ACC_W'(frame_interval));
	assign step_sum = cur_x + (back_q ? {(FW + 1){1'b1}} : (FW + 1)'(1));

	// Repeating modes wrap the stepped frame into 0..n-1, also from below zero.
	assign sum_neg = -sum_q;
	assign sum_abs = sum_q[FW] ? sum_neg[FW-1:0] : sum_q[FW-1:0];
	always_comb begin
		if (!sum_q[FW]) begin
			mod_frame = FW'(div_rsp.rem);
		end else if (div_rsp.rem == '0) begin
			mod_frame = '0;
		end else begin
			mod_frame = FW'(n_eff - div_rsp.rem);
		end
	end

	assign land_flip = pp && ((nxt_x >= n_s - (FW + 1)'(1)) ||
		(rep && (nxt_x <= (FW + 1)'(0))));
	assign land_in_range = !nxt_q[FW-1] && (nxt_x < n_s);

	// One multiplier serves both sheet offsets in consecutive cycles.
	assign mul_a = (state_q == sfs_pkg::ST_MUL_LEFT) ?
		sfs_pkg::PROD_W'(col_q) : sfs_pkg::PROD_W'(row_q);
	assign mul_b = (state_q == sfs_pkg::ST_MUL_LEFT) ?
		sfs_pkg::PROD_W'(cfg.frame_width) : sfs_pkg::PROD_W'(cfg.frame_height);
	assign prod = mul_a * mul_b;

	always_comb begin
		result_d.frame_index = cur_q;
		result_d.sheet_left = left_q;
		result_d.sheet_top = top_q;
		result_d.visible = (dly_q == '0);
		result_d.expired = exp_now;
		result_d.frame_advanced = adv_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		out_load = 1'b0;
		div_req.start = 1'b0;
		div_req.dividend = sum_abs;
		div_req.divisor = n_eff;
		unique case (state_q)
			sfs_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = sfs_pkg::ST_EVAL;
			end
			sfs_pkg::ST_EVAL: begin
				state_d = (dly_q != '0) ? sfs_pkg::ST_FINISH : sfs_pkg::ST_CHECK;
			end
			sfs_pkg::ST_CHECK: begin
				if (!step_ok) begin
					state_d = sfs_pkg::ST_FINISH;
				end else if (rep) begin
					state_d = sfs_pkg::ST_MOD_GO;
				end else begin
					state_d = sfs_pkg::ST_LAND;
				end
			end
			sfs_pkg::ST_MOD_GO: begin
				div_req.start = 1'b1;
				state_d = sfs_pkg::ST_MOD_WAIT;
			end
			sfs_pkg::ST_MOD_WAIT: begin
				if (div_rsp.done) state_d = sfs_pkg::ST_LAND;
			end
			sfs_pkg::ST_LAND: begin
				state_d = land_in_range ? sfs_pkg::ST_ROW_GO : sfs_pkg::ST_FINISH;
			end
			sfs_pkg::ST_ROW_GO: begin
				div_req.start = 1'b1;
				div_req.dividend = cur_q;
				div_req.divisor = fpr_eff;
				state_d = sfs_pkg::ST_ROW_WAIT;
			end
			sfs_pkg::ST_ROW_WAIT: begin
				if (div_rsp.done) state_d = sfs_pkg::ST_MUL_LEFT;
			end
			sfs_pkg::ST_MUL_LEFT: state_d = sfs_pkg::ST_MUL_TOP;
			sfs_pkg::ST_MUL_TOP:  state_d = sfs_pkg::ST_FINISH;
			sfs_pkg::ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d = sfs_pkg::ST_IDLE;
				end
			end
			default: state_d = sfs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			back_q <= 1'b0;
			acc_q <= '0;
			alive_q <= '0;
			dly_q <= '0;
			left_q <= '0;
			top_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (delay_load) begin
				dly_q <= delay_value;
			end else if (state_q == sfs_pkg::ST_EVAL && dly_q != '0) begin
				dly_q <= (tick_q >= dly_q) ? '0 : dly_q - tick_q;
			end
			if (state_q == sfs_pkg::ST_EVAL && dly_q == '0) begin
				acc_q <= acc_sat;
				alive_q <= alive_sat;
			end
			if (state_q == sfs_pkg::ST_CHECK && step_ok) begin
				acc_q <= acc_q - ACC_W'(frame_interval);
			end
			if (state_q == sfs_pkg::ST_LAND) begin
				cur_q <= nxt_q;
				if (land_flip) back_q <= !back_q;
			end
			if (state_q == sfs_pkg::ST_MUL_LEFT) left_q <= prod[sfs_pkg::OFS_W-1:0];
			if (state_q == sfs_pkg::ST_MUL_TOP) top_q <= prod[sfs_pkg::OFS_W-1:0];
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) tick_q <= tick_time;
		if (state_q == sfs_pkg::ST_EVAL) begin
			wexp_q <= exp_now;
			adv_q <= 1'b0;
		end
		if (state_q == sfs_pkg::ST_CHECK) begin
			adv_q <= step_ok;
			sum_q <= step_sum;
			nxt_q <= step_sum[FW-1:0];
		end
		if (state_q == sfs_pkg::ST_MOD_WAIT && div_rsp.done) nxt_q <= mod_frame;
		if (state_q == sfs_pkg::ST_ROW_WAIT && div_rsp.done) begin
			col_q <= div_rsp.rem;
			row_q <= div_rsp.quot[CW-1:0];
		end
		if (out_load) out_q <= result_d;
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

@@ sv/sprite_frame_sequencer_top.sv @@
`timescale 1ns / 1ps
// Top level of the sprite frame sequencer: register port, sequencer, shared divider.
// Depends on sfs_pkg, sfs_ifs, sfs_regs, sfs_div and sfs_seq.
//
// Usage: each item on the tick channel carries the time elapsed since the previous
// tick. For every tick the block returns exactly one item on the res channel with
// the current frame index, the frame's pixel offset in the sprite sheet, and the
// visible, expired and frame_advanced flags. Both channels are valid/ready.
// The block handles one tick at a time. A tick inside the start delay passes through
// the EVAL and FINISH states, a running tick that steps no frame through EVAL, CHECK
// and FINISH. A step runs the serial divider once for the wrap of a repeating mode and,
// if the new frame lies inside the animation, once to split it into column and row,
// then the left and top multiplier states, before FINISH. The next tick is taken
// once the result has been loaded into the output register.
// tick.ready is high only while the block is idle.
// The result sits in an output register; if the receiver stalls, the block still
// takes the next tick and holds that tick's result until the register frees.
// Reset (arst_n low) restores all registers to their reset values, the frame to 0
// stepping forward, and clears the time accumulators. Configuration is written over
// the APB port while no tick is in flight; writing start_delay restarts the delay.
module sprite_frame_sequencer_top #(
	parameter int TIME_BITS = 24,
	parameter int MAX_FRAMES = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	sfs_tick_if.sink                    tick,
	sfs_res_if.source                   res,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sfs_pkg::APB_AW-1:0] paddr,
	input  logic [sfs_pkg::APB_DW-1:0] pwdata,
	output logic [sfs_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);

	logic [TIME_BITS-1:0]  frame_interval;
	sfs_pkg::sfs_cfg_t     cfg;
	logic                  delay_load;
	logic [TIME_BITS-1:0]  delay_value;
	sfs_pkg::sfs_div_req_t div_req;
	sfs_pkg::sfs_div_rsp_t div_rsp;
	sfs_pkg::sfs_result_t  out_data;
	logic                  out_valid;
	logic                  in_ready;

	sfs_regs #(
		.TIME_BITS(TIME_BITS)
	) u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.frame_interval(frame_interval),
		.cfg(cfg),
		.delay_load(delay_load),
		.delay_value(delay_value)
	);

	sfs_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	sfs_seq #(
		.TIME_BITS(TIME_BITS),
		.MAX_FRAMES(MAX_FRAMES)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.frame_interval(frame_interval),
		.cfg(cfg),
		.delay_load(delay_load),
		.delay_value(delay_value),
		.in_valid(tick.valid),
		.in_ready(in_ready),
		.tick_time(tick.tick_time),
		.out_valid(out_valid),
		.out_ready(res.ready),
		.out_data(out_data),
		.div_req(div_req),
		.div_rsp(div_rsp)
	);

	assign tick.ready = in_ready;
	assign res.valid = out_valid;
	assign res.frame_index = out_data.frame_index;
	assign res.sheet_left = out_data.sheet_left;
	assign res.sheet_top = out_data.sheet_top;
	assign res.visible = out_data.visible;
	assign res.expired = out_data.expired;
	assign res.frame_advanced = out_data.frame_advanced;

`ifndef SYNTH
	// After taking a tick the block is busy at least for the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		tick.valid && tick.ready |=> !tick.ready)
		else $error("tick accepted on two consecutive cycles");

	// A frame step only happens once the start delay has run out.
	a_step_is_visible: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.frame_advanced |-> res.visible)
		else $error("frame stepped while still hidden");

	// Repeating forward play always lands on a frame inside the animation.
	a_repeat_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.frame_advanced && cfg.play_mode[sfs_pkg::MODE_REPEAT_BIT] &&
		!cfg.play_mode[sfs_pkg::MODE_PINGPONG_BIT] && (cfg.frame_count != '0) &&
		(int'(cfg.frame_count) <= MAX_FRAMES)
		|-> !res.frame_index[sfs_pkg::FRAME_W-1] &&
		(res.frame_index[sfs_pkg::CNT_W-1:0] < cfg.frame_count))
		else $error("repeating frame index out of range");
`endif

endmodule

@@ verif/sfs_frame_checker.sv @@
`timescale 1ns / 1ps
// Frame checker for the sprite frame sequencer: follows the register writes and
// tick items, predicts each result item and compares it with what the block sends.
// Depends on sfs_pkg and sfs_ifs.
module sfs_frame_checker
	import sfs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	sfs_tick_if               tick,
	sfs_res_if                res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	input  logic              pready,
	output int                misses,
	output int                waiting,
	output int                results_seen,
	output int                steps_seen,
	output int                expired_seen
);

	localparam int T_BITS = 24;
	localparam int FRAME_LIMIT = 256;
	localparam longint ACC_FULL = (longint'(1) << (T_BITS + 1)) - 1;
	localparam longint ALIVE_FULL = 64'h0000_0000_FFFF_FFFF;

	// Register copies.
	logic [T_BITS-1:0] interval_r;
	logic [LIFE_W-1:0] lifespan_r;
	logic [CNT_W-1:0]  count_r;
	logic [CNT_W-1:0]  per_row_r;
	logic [MODE_W-1:0] mode_r;
	logic [DIM_W-1:0]  width_r;
	logic [DIM_W-1:0]  height_r;

	// Animation state.
	logic signed [FRAME_W-1:0] frame;
	logic                      backward;
	logic [T_BITS:0]           accum;
	logic [LIFE_W-1:0]         alive;
	logic [T_BITS-1:0]         delay_left;
	logic [OFS_W-1:0]          held_left;
	logic [OFS_W-1:0]          held_top;

	sfs_result_t frames_due[$];
	sfs_result_t want;
	sfs_result_t seen;

	function automatic int frame_span();
		int n;
		n = int'(count_r);
		if (n == 0) n = 1;
		if (n > FRAME_LIMIT) n = FRAME_LIMIT;
		return n;
	endfunction

	function automatic bit run_over();
		bit once;
		once = !mode_r[MODE_REPEAT_BIT];
		if (lifespan_r != 0 && alive > lifespan_r) return 1'b1;
		if (mode_r[MODE_PINGPONG_BIT]) return once && int'(frame) < 0;
		return once && int'(frame) >= frame_span();
	endfunction

	function automatic void step_frame();
		int n;
		int nxt;
		int per;
		bit rep;
		n = frame_span();
		rep = mode_r[MODE_REPEAT_BIT];
		nxt = int'(frame) + (backward ? -1 : 1);
		if (rep) nxt = (nxt < 0) ? (n - ((-nxt) % n)) % n : nxt % n;
		frame = FRAME_W'(nxt);
		if (mode_r[MODE_PINGPONG_BIT]) begin
			if (rep && (int'(frame) >= n - 1 || int'(frame) <= 0))
				backward = !backward;
			else if (!rep && int'(frame) >= n - 1)
				backward = !backward;
		end
		// The sheet cell only moves when the new frame is a real frame.
		if (int'(frame) >= 0 && int'(frame) < n) begin
			per = (per_row_r == 0) ? 1 : int'(per_row_r);
			held_left = OFS_W'((int'(frame) % per) * int'(width_r));
			held_top = OFS_W'((int'(frame) / per) * int'(height_r));
		end
	endfunction

	function automatic sfs_result_t advance_animation(input logic [T_BITS-1:0] t);
		sfs_result_t r;
		longint sum;
		bit was_over;
		bit adv;
		adv = 1'b0;
		if (delay_left != 0) begin
			delay_left = (t >= delay_left) ? '0 : delay_left - t;
		end else begin
			was_over = run_over();
			sum = longint'(accum) + longint'(t);
			accum = (sum > ACC_FULL) ? '1 : (T_BITS + 1)'(sum);
			sum = longint'(alive) + longint'(t);
			alive = (sum > ALIVE_FULL) ? '1 : LIFE_W'(sum);
			if (!was_over && accum >= interval_r) begin
				step_frame();
				accum = accum - interval_r;
				adv = 1'b1;
			end
		end
		r.frame_index = frame;
		r.sheet_left = held_left;
		r.sheet_top = held_top;
		r.visible = (delay_left == 0);
		r.expired = run_over();
		r.frame_advanced = adv;
		return r;
	endfunction

	function automatic void write_setting(input logic [APB_AW-1:0] addr,
		input logic [APB_DW-1:0] v);
		case (sfs_reg_e'(addr[APB_AW-1:2]))
			REG_FRAME_INTERVAL: interval_r = v[T_BITS-1:0];
			REG_START_DELAY:    delay_left = v[T_BITS-1:0];
			REG_LIFESPAN:       lifespan_r = v[LIFE_W-1:0];
			REG_FRAME_COUNT:    count_r = v[CNT_W-1:0];
			REG_FRAMES_PER_ROW: per_row_r = v[CNT_W-1:0];
			REG_PLAY_MODE:      mode_r = v[MODE_W-1:0];
			REG_FRAME_WIDTH:    width_r = v[DIM_W-1:0];
			REG_FRAME_HEIGHT:   height_r = v[DIM_W-1:0];
			default: ;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_r = T_BITS'(FRAME_INTERVAL_RESET);
			lifespan_r = '0;
			count_r = FRAME_COUNT_RESET;
			per_row_r = FRAMES_PER_ROW_RESET;
			mode_r = '0;
			width_r = FRAME_DIM_RESET;
			height_r = FRAME_DIM_RESET;
			frame = '0;
			backward = 1'b0;
			accum = '0;
			alive = '0;
			delay_left = '0;
			held_left = '0;
			held_top = '0;
			frames_due.delete();
			misses = 0;
			waiting = 0;
			results_seen = 0;
			steps_seen = 0;
			expired_seen = 0;
		end else begin
			if (psel && penable && pwrite && pready) write_setting(paddr, pwdata);
			// The result is checked before this edge's tick is predicted.
			if (res.valid && res.ready) begin
				seen.frame_index = res.frame_index;
				seen.sheet_left = res.sheet_left;
				seen.sheet_top = res.sheet_top;
				seen.visible = res.visible;
				seen.expired = res.expired;
				seen.frame_advanced = res.frame_advanced;
				results_seen++;
				if (seen.frame_advanced) steps_seen++;
				if (seen.expired) expired_seen++;
				if (frames_due.size() == 0) begin
					misses++;
					if (misses <= 10)
						$display("result %0d arrived with no tick outstanding", results_seen);
				end else begin
					want = frames_due.pop_front();
					if (want !== seen) begin
						misses++;
						if (misses <= 10) begin
							$display("mismatch on result %0d: expected frame %0d left %0d top %0d",
								results_seen, want.frame_index, want.sheet_left, want.sheet_top,
								" visible %0b expired %0b advanced %0b", want.visible,
								want.expired, want.frame_advanced);
							$display("  received frame %0d left %0d top %0d", seen.frame_index,
								seen.sheet_left, seen.sheet_top, " visible %0b expired %0b",
								seen.visible, seen.expired, " advanced %0b", seen.frame_advanced);
						end
					end
				end
			end
			if (tick.valid && tick.ready)
				frames_due.push_back(advance_animation(tick.tick_time));
			waiting = frames_due.size();
		end
	end

endmodule

@@ verif/tb_sprite_frame_sequencer_top.sv @@
`timescale 1ns / 1ps
// Testbench top for the sprite frame sequencer: clock, reset, tick and register
// stimulus, result back-pressure and the verdict. Depends on sfs_pkg, sfs_ifs,
// sfs_frame_checker and the sprite_frame_sequencer_top RTL.
module tb_sprite_frame_sequencer_top;
	import sfs_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int RESET_CYCLES = 10;
	localparam int ITEM_TARGET = 600;
	// The last part of the run is sent with no idling on either side.
	localparam int CALM_FROM = 480;
	// A receiver hold-off long enough to fill the block and stall the tick input.
	localparam int LONG_HOLD = 300;
	// The quiet limit is many times the long hold-off and the slowest item, including
	// the random idle gaps on either side.
	localparam int QUIET_LIMIT = 3000;
	// Cycles left after the last result before the verdict.
	localparam int TAIL_CYCLES = 40;
	localparam logic [MODE_W-1:0] PLAY_LOOP = MODE_W'(1 << MODE_REPEAT_BIT);
	localparam logic [MODE_W-1:0] PLAY_BOUNCE_ONCE = MODE_W'(1 << MODE_PINGPONG_BIT);

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	sfs_tick_if #(.TIME_BITS(24)) tick_ch ();
	sfs_res_if res_ch ();

	int misses;
	int waiting;
	int results_seen;
	int steps_seen;
	int expired_seen;

	// Stimulus bookkeeping shared by the sender, the receiver and the watchdog.
	int ticks_sent = 0;
	longint time_sent = 0;
	int setups = 0;
	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	int hold_span = 0;
	int quiet = 0;
	logic [23:0] iv;

	always #HALF_PERIOD clk = ~clk;

	sprite_frame_sequencer_top #(
		.TIME_BITS(24),
		.MAX_FRAMES(256)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.tick(tick_ch),
		.res(res_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	sfs_frame_checker frame_check (
		.clk(clk),
		.arst_n(arst_n),
		.tick(tick_ch),
		.res(res_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.pready(pready),
		.misses(misses),
		.waiting(waiting),
		.results_seen(results_seen),
		.steps_seen(steps_seen),
		.expired_seen(expired_seen)
	);

	// One register write: a setup phase, then an access phase that completes on
	// pready. The select is left high so that writes can follow back to back.
	task automatic write_reg(input sfs_reg_e idx, input logic [APB_DW-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic apb_release();
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Offers one tick item and returns at the edge that accepts it. Valid stays
	// high into the next item unless a random gap is taken first.
	task automatic send_tick(input logic [23:0] t);
		if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
			tick_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.tick_time <= t;
		do @(posedge clk); while (!tick_ch.ready);
		ticks_sent++;
		time_sent += t;
	endtask

	// Stops offering ticks and waits until every predicted result has come back.
	// The count is looked at on the falling edge, after the checker has updated.
	task automatic settle();
		tick_ch.valid <= 1'b0;
		do @(negedge clk); while (waiting != 0);
		@(posedge clk);
	endtask

	// Tick sizes mostly run up to twice a frame interval of 1 to 300, else up to 600,
	// so that steps are frequent, with zero, all ones and full-range values mixed in.
	function automatic logic [23:0] pick_tick(input logic [23:0] interval);
		int typ;
		typ = (interval > 0 && interval <= 300) ? 2 * int'(interval) : 600;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return 24'($urandom());
			default: return 24'($urandom_range(0, typ));
		endcase
	endfunction

	function automatic logic [DIM_W-1:0] pick_dim();
		case ($urandom_range(0, 5))
			0: return '1;
			1: return DIM_W'(1);
			2: return '0;
			3: return DIM_W'(4096);
			default: return DIM_W'($urandom_range(1, 8191));
		endcase
	endfunction

	function automatic logic [CNT_W-1:0] pick_count(input int typ_high);
		case ($urandom_range(0, 7))
			0: return '0;
			1: return CNT_W'(256);
			2: return CNT_W'($urandom_range(257, 511));
			3: return CNT_W'(1);
			default: return CNT_W'($urandom_range(1, typ_high));
		endcase
	endfunction

	// Writes every register with a fresh random setting. The lifespan is often
	// set a little beyond the time sent so far, so that expiry falls inside the
	// phase rather than at once.
	task automatic random_setup();
		logic [23:0] delay;
		logic [31:0] life;
		longint reach;
		case ($urandom_range(0, 9))
			0: iv = '0;
			1: iv = '1;
			2: iv = 24'($urandom());
			3: iv = 24'd1;
			default: iv = 24'($urandom_range(2, 300));
		endcase
		case ($urandom_range(0, 9))
			7, 8: delay = 24'($urandom_range(1, 3000));
			9: delay = 24'($urandom_range(1, 20000));
			default: delay = '0;
		endcase
		reach = time_sent + longint'($urandom_range(0, 30000));
		case ($urandom_range(0, 9))
			5: life = '1;
			6: life = $urandom();
			7, 8, 9: life = (reach > 64'hFFFF_FFFF) ? '1 : 32'(reach);
			default: life = '0;
		endcase
		write_reg(REG_FRAME_INTERVAL, APB_DW'(iv));
		write_reg(REG_START_DELAY, APB_DW'(delay));
		write_reg(REG_LIFESPAN, life);
		write_reg(REG_FRAME_COUNT, APB_DW'(pick_count(12)));
		write_reg(REG_FRAMES_PER_ROW, APB_DW'(pick_count(6)));
		write_reg(REG_PLAY_MODE, APB_DW'($urandom_range(0, 3)));
		write_reg(REG_FRAME_WIDTH, APB_DW'(pick_dim()));
		write_reg(REG_FRAME_HEIGHT, APB_DW'(pick_dim()));
		apb_release();
		setups++;
	endtask

	// Receiver: accepts results with random stall bursts, or holds off for one
	// long stretch when asked, so that the block backs up into its tick input.
	initial begin : result_sink
		int gap;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_span > 0) begin
				res_ch.ready <= 1'b0;
				repeat (hold_span) @(posedge clk);
				hold_span = 0;
			end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
				gap = $urandom_range(1, 6);
				res_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end else begin
				res_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Watchdog: the run is stuck when no item, result or register write has been
	// accepted for a long stretch.
	always @(posedge clk) begin
		if (!arst_n || (tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready)
			|| (psel && penable))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("no progress for %0d cycles with %0d results outstanding", quiet, waiting);
			$display("sprite_frame_sequencer_top regression: fail");
			$finish;
		end
	end

	initial begin : stimulus
		int items;
		int phase;
		tick_ch.valid <= 1'b0;
		tick_ch.tick_time <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		iv = 24'(FRAME_INTERVAL_RESET);
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Power-on settings: one frame, one-shot forward. The first full-range tick
		// steps past the only frame and ends the run of frames; the further ones
		// only fill the time accumulator until it saturates.
		send_tick('0);
		send_tick('1);
		send_tick('1);
		send_tick('1);
		settle();

		// Longest start delay, zero interval and a repeating loop of five frames on
		// a wide sheet. The delay takes three ticks to clear, after which every tick
		// steps a frame without taking time off the accumulator.
		write_reg(REG_START_DELAY, APB_DW'(24'hFF_FFFF));
		write_reg(REG_FRAME_INTERVAL, '0);
		write_reg(REG_FRAME_COUNT, APB_DW'(5));
		write_reg(REG_FRAMES_PER_ROW, APB_DW'(2));
		write_reg(REG_PLAY_MODE, APB_DW'(PLAY_LOOP));
		write_reg(REG_FRAME_WIDTH, APB_DW'(8191));
		write_reg(REG_FRAME_HEIGHT, APB_DW'(4096));
		write_reg(REG_LIFESPAN, '1);
		apb_release();
		iv = '0;
		send_tick(24'hFF_FFFE);
		send_tick('0);
		send_tick(24'd1);
		repeat (6) send_tick('0);
		settle();

		// A single repeating frame brings the animation back to frame zero.
		write_reg(REG_START_DELAY, '0);
		write_reg(REG_FRAME_INTERVAL, APB_DW'(10));
		write_reg(REG_FRAME_COUNT, APB_DW'(1));
		write_reg(REG_LIFESPAN, '0);
		apb_release();
		iv = 24'd10;
		send_tick(24'd10);
		settle();

		// One-shot ping-pong over three frames: up to the last frame, turn, back
		// down past frame zero to the end marker, where the frame then holds.
		write_reg(REG_FRAME_COUNT, APB_DW'(3));
		write_reg(REG_PLAY_MODE, APB_DW'(PLAY_BOUNCE_ONCE));
		apb_release();
		repeat (6) send_tick(24'd10);
		settle();

		// Still stepping backward, a repeating forward mode wraps the negative
		// frame around a count above the limit, with zero frames per row.
		write_reg(REG_FRAME_COUNT, APB_DW'(300));
		write_reg(REG_FRAMES_PER_ROW, '0);
		write_reg(REG_PLAY_MODE, APB_DW'(PLAY_LOOP));
		apb_release();
		repeat (3) send_tick(24'd10);
		settle();

		// Random phases: each one starts from idle with a new setting of every
		// register, sends a burst of ticks and drains all results before the next.
		phase = 0;
		while (ticks_sent < ITEM_TARGET) begin
			if (ticks_sent >= CALM_FROM) begin
				src_idle_pct = 0;
				sink_idle_pct = 0;
			end else begin
				case ($urandom_range(0, 3))
					0: src_idle_pct = 0;
					1: src_idle_pct = 10;
					2: src_idle_pct = 25;
					default: src_idle_pct = 50;
				endcase
				case ($urandom_range(0, 3))
					0: sink_idle_pct = 0;
					1: sink_idle_pct = 10;
					2: sink_idle_pct = 25;
					default: sink_idle_pct = 50;
				endcase
			end
			random_setup();
			// One early phase has the receiver stall for a long time while ticks
			// keep coming, so the output register and the input both back up.
			if (phase == 2) hold_span = LONG_HOLD;
			items = $urandom_range(20, 60);
			repeat (items) send_tick(pick_tick(iv));
			settle();
			phase++;
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("%0d ticks over %0d random register setups; %0d results checked,", ticks_sent,
			setups, results_seen, " %0d with a frame step and %0d flagged expired", steps_seen,
			expired_seen);
		if (misses == 0 && waiting == 0) begin
			$display("sprite_frame_sequencer_top regression: pass");
		end else begin
			$display("%0d mismatches, %0d results never arrived", misses, waiting);
			$display("sprite_frame_sequencer_top regression: fail");
		end
		$finish;
	end

endmodule
